/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied
`define ULVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ULVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/ulvc_pkg.sv */
package ulvc_pkg;

  // Width of the internal valid-line counter; the result field holds its low 32 bits
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned RES_COUNT_W = 32;

  localparam int unsigned IN_TDATA_W  = 8;
  // line_valid (1) + valid_line_count (32), padded to whole bytes
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Byte codes
  localparam logic [7:0] BYTE_NL     = 8'h0A;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD3_SURR  = 8'hED;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [7:0] CONT_A0     = 8'hA0;
  localparam logic [7:0] CONT_9F     = 8'h9F;
  localparam logic [7:0] CONT_90     = 8'h90;
  localparam logic [7:0] CONT_8F     = 8'h8F;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;

  // Allowed range of the next continuation byte
  typedef enum logic [2:0] {
    KIND_ANY = 3'd0,  // 80-BF
    KIND_E0  = 3'd1,  // A0-BF
    KIND_ED  = 3'd2,  // 80-9F
    KIND_F0  = 3'd3,  // 90-BF
    KIND_F4  = 3'd4   // 80-8F
  } kind_e;

  typedef struct packed {
    logic       final_byte;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic                   input_done;
    logic [RES_COUNT_W-1:0] valid_line_count;
    logic                   line_valid;
  } res_word_t;

  // Checker state made visible to the top level
  typedef struct packed {
    logic [1:0] pending;
    kind_e      kind;
    logic       broken;
    logic       count_zero;
  } chk_status_t;

  function automatic logic cont_ok(input logic [7:0] b, input kind_e kind);
    logic ok;
    unique case (kind)
      KIND_E0: ok = (b >= CONT_A0) && ((b & CONT_MASK) == CONT_TAG);
      KIND_ED: ok = (b >= CONT_TAG) && (b <= CONT_9F);
      KIND_F0: ok = (b >= CONT_90) && ((b & CONT_MASK) == CONT_TAG);
      KIND_F4: ok = (b >= CONT_TAG) && (b <= CONT_8F);
      default: ok = ((b & CONT_MASK) == CONT_TAG);
    endcase
    return ok;
  endfunction

endpackage

/* rtl/ulvc_in_stage.sv */
module ulvc_in_stage
  import ulvc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] text_byte
  input  logic                  s_axis_tlast,   // final_byte
  input  logic                  take_i,
  output logic                  valid_o,
  output in_word_t              word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  // Register may refill in the same cycle the checker takes its word
  assign s_axis_tready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      word_q.text_byte  <= s_axis_tdata;
      word_q.final_byte <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* rtl/ulvc_line_check.sv */
module ulvc_line_check
  import ulvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  in_word_t    word_i,
  input  logic        out_free_i,
  output logic        take_o,
  output logic        load_o,
  output res_word_t   res_o,
  output chk_status_t status_o
);

  logic [1:0]             pending_q, pending_d;
  kind_e                  kind_q, kind_d;
  logic                   broken_q, broken_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  logic [1:0]             pend_n;
  kind_e                  kind_n;
  logic                   broken_n;
  logic                   is_nl, emit, line_ok;
  logic [COUNT_WIDTH-1:0] count_n;
  logic [7:0]             b;

  assign b     = word_i.text_byte;
  assign is_nl = (b == BYTE_NL);
  assign emit  = is_nl || word_i.final_byte;

  // A word with a result waits for room in the output register
  assign take_o = valid_i && (!emit || out_free_i);
  assign load_o = take_o && emit;

  // Decode of one byte against the line state
  always_comb begin
    pend_n   = pending_q;
    kind_n   = kind_q;
    broken_n = broken_q;
    if (!is_nl && !broken_q) begin
      if (pending_q != 2'd0) begin
        if (!cont_ok(b, kind_q)) begin
          broken_n = 1'b1;
        end
        pend_n = pending_q - 2'd1;
        kind_n = KIND_ANY;
      end else begin
        priority if (!b[7]) begin
          pend_n = pending_q;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          pend_n = 2'd1;
          kind_n = KIND_ANY;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          pend_n = 2'd2;
          kind_n = (b == LEAD3_LO) ? KIND_E0 : (b == LEAD3_SURR) ? KIND_ED : KIND_ANY;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          pend_n = 2'd3;
          kind_n = (b == LEAD4_LO) ? KIND_F0 : (b == LEAD4_HI) ? KIND_F4 : KIND_ANY;
        end else begin
          broken_n = 1'b1;
        end
      end
    end
  end

  // Line verdict and saturating count
  always_comb begin
    line_ok = !broken_n && (pend_n == 2'd0);
    count_n = count_q;
    if (line_ok && (count_q != COUNT_MAX)) begin
      count_n = count_q + COUNT_WIDTH'(1);
    end
  end

  assign res_o.line_valid       = line_ok;
  assign res_o.valid_line_count = RES_COUNT_W'(count_n);
  assign res_o.input_done       = word_i.final_byte;

  // Next state
  always_comb begin
    pending_d = pending_q;
    kind_d    = kind_q;
    broken_d  = broken_q;
    count_d   = count_q;
    if (take_o) begin
      if (emit) begin
        pending_d = 2'd0;
        kind_d    = KIND_ANY;
        broken_d  = 1'b0;
        count_d   = word_i.final_byte ? '0 : count_n;
      end else begin
        pending_d = pend_n;
        kind_d    = kind_n;
        broken_d  = broken_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      kind_q    <= KIND_ANY;
      broken_q  <= 1'b0;
      count_q   <= '0;
    end else begin
      pending_q <= pending_d;
      kind_q    <= kind_d;
      broken_q  <= broken_d;
      count_q   <= count_d;
    end
  end

  assign status_o.pending    = pending_q;
  assign status_o.kind       = kind_q;
  assign status_o.broken     = broken_q;
  assign status_o.count_zero = (count_q == '0);

endmodule

/* rtl/ulvc_out_stage.sv */
module ulvc_out_stage
  import ulvc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  res_word_t              res_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [0] line_valid, [32:1] valid_line_count
  output logic                   m_axis_tlast   // input_done
);

  logic      valid_q, valid_d;
  res_word_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({res_q.valid_line_count, res_q.line_valid});
  assign m_axis_tlast  = res_q.input_done;

endmodule

/* rtl/utf8_line_validity_counter.sv */
// Channel  Dir  tdata                                  tlast        tuser
// s_axis   in   [7:0] text_byte                        final_byte   -
// m_axis   out  [0] line_valid, [32:1] valid_line_cnt  input_done   -
//
// One byte per clock while m_axis is not stalled; a line result is presented on
// m_axis once its closing byte has passed the input register, then the result register.
// rst_ni is asynchronous, active low; it clears line state, the count and
// both valid flags. A stalled m_axis holds back only bytes that close a line;
// other bytes keep flowing while a result waits.
`include "assert_macros.svh"

module utf8_line_validity_counter
  import ulvc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tlast,   // final_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] line_valid, [32:1] valid_line_count
  output logic                   m_axis_tlast    // input_done
);

  logic        in_valid, take, load, out_free;
  in_word_t    in_word;
  res_word_t   res;
  chk_status_t status;

  ulvc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .valid_o       (in_valid),
    .word_o        (in_word)
  );

  ulvc_line_check u_line_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid),
    .word_i     (in_word),
    .out_free_i (out_free),
    .take_o     (take),
    .load_o     (load),
    .res_o      (res),
    .status_o   (status)
  );

  ulvc_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A narrowed second-byte range only follows a three- or four-byte lead
  `ULVC_ASSERT(a_kind_needs_pending,
               (status.kind != KIND_ANY) |-> (status.pending >= 2'd2),
               "narrowed range without pending continuations")
  // A result is never written over one still waiting
  `ULVC_ASSERT(a_no_overwrite, load |-> (!m_axis_tvalid || m_axis_tready),
               "result register overwritten")
  // The end of the input restarts the count and the line state
  `ULVC_ASSERT(a_final_clears,
               (load && res.input_done) |=>
                 (status.count_zero && !status.broken && (status.pending == 2'd0)),
               "state not cleared after final byte")
  // A word that reaches the result register came from the input register
  `ULVC_ASSERT_ALWAYS(a_load_has_word, load |-> in_valid,
                      "result loaded without an input word")

endmodule

/* verif/tb_utf8_line_validity_counter.sv */
`timescale 1ns / 100ps

module tb_utf8_line_validity_counter;
  import ulvc_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1800;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AFTER     = 40;
  localparam int unsigned PRINT_LIMIT    = 30;
  localparam logic [7:0]  CONT_HI        = 8'hBF;

  // One directed word, with the expected line result where it is obvious
  typedef struct packed {
    logic [7:0]  text;
    logic        fin;
    logic        typed;
    logic        ok;
    logic [31:0] cnt;
    logic        done;
  } dir_row_t;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    res_word_t want;
  } stim_t;

  localparam int unsigned N_DIRECTED = 30;

  // text, final, typed, line_valid, count, input_done
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0},  // plain ASCII line
    '{8'hC2, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hDF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hED, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b1, 1'b1, 32'd2, 1'b0},  // leads for every range kind, continuations at range edges
    '{8'hE0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},  // below the E0 second-byte range
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},  // ignored, line already failed
    '{8'h0A, 1'b0, 1'b1, 1'b0, 32'd2, 1'b0},
    '{8'hC2, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b1, 1'b0, 32'd2, 1'b0},  // sequence cut by newline
    '{8'h80, 1'b1, 1'b1, 1'b0, 32'd2, 1'b1},  // stray continuation as final byte
    '{8'h0A, 1'b1, 1'b1, 1'b1, 32'd1, 1'b1}   // final newline on a fresh input
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] text_byte
  logic                   s_axis_tlast  = 1'b0;  // final_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [0] line_valid, [32:1] valid_line_count
  logic                   m_axis_tlast;  // input_done

  // Predictor state
  logic [1:0]             cont_due    = 2'd0;
  kind_e                  next_kind   = KIND_ANY;
  logic                   line_bad    = 1'b0;
  logic [COUNT_WIDTH-1:0] valid_lines = '0;

  stim_t     stim_q[$];
  res_word_t line_results[$];
  int unsigned n_taken    = 0;
  int unsigned n_results  = 0;
  int unsigned mismatches = 0;
  int unsigned idle_count = 0;

  utf8_line_validity_counter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    mismatches++;
  endtask

  // Advance the line checker by one word; closes is set when a line ends
  task automatic track_line_byte(input in_word_t w, output logic closes,
                                 output res_word_t r);
    logic [7:0] b;
    logic       ok;
    b      = w.text_byte;
    closes = 1'b0;
    r      = '0;
    if (b != BYTE_NL && !line_bad) begin
      if (cont_due != 2'd0) begin
        case (next_kind)
          KIND_E0: ok = (b >= CONT_A0) && (b <= CONT_HI);
          KIND_ED: ok = (b >= CONT_TAG) && (b <= CONT_9F);
          KIND_F0: ok = (b >= CONT_90) && (b <= CONT_HI);
          KIND_F4: ok = (b >= CONT_TAG) && (b <= CONT_8F);
          default: ok = ((b & CONT_MASK) == CONT_TAG);
        endcase
        if (!ok) line_bad = 1'b1;
        cont_due  = cont_due - 2'd1;
        next_kind = KIND_ANY;
      end else if (b[7]) begin
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          cont_due  = 2'd1;
          next_kind = KIND_ANY;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          cont_due  = 2'd2;
          next_kind = (b == LEAD3_LO) ? KIND_E0 : (b == LEAD3_SURR) ? KIND_ED : KIND_ANY;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          cont_due  = 2'd3;
          next_kind = (b == LEAD4_LO) ? KIND_F0 : (b == LEAD4_HI) ? KIND_F4 : KIND_ANY;
        end else begin
          line_bad = 1'b1;
        end
      end
    end
    // Line end: newline or the final word of the input
    if (b == BYTE_NL || w.final_byte) begin
      ok = !line_bad && (cont_due == 2'd0);
      if (ok && valid_lines != COUNT_MAX) valid_lines = valid_lines + COUNT_WIDTH'(1);
      closes             = 1'b1;
      r.line_valid       = ok;
      r.valid_line_count = valid_lines[RES_COUNT_W-1:0];
      r.input_done       = w.final_byte;
      cont_due           = 2'd0;
      next_kind          = KIND_ANY;
      line_bad           = 1'b0;
      if (w.final_byte) valid_lines = '0;
    end
  endtask

  task automatic add_word(input logic [7:0] b, input logic fin, input logic typed,
                          input res_word_t want);
    stim_t s;
    s.w.text_byte  = b;
    s.w.final_byte = fin;
    s.typed        = typed;
    s.want         = want;
    stim_q.push_back(s);
  endtask

  // Continuation byte in the range allowed by kind, edges favoured
  function automatic logic [7:0] rand_cont(input kind_e k);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_TAG;
    hi = CONT_HI;
    case (k)
      KIND_E0: lo = CONT_A0;
      KIND_ED: hi = CONT_9F;
      KIND_F0: lo = CONT_90;
      KIND_F4: hi = CONT_8F;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  // Random text: mostly well-formed lines, some truncated, corrupted or noisy
  task automatic build_random_text();
    logic [7:0] q[$];
    logic [7:0] b;
    logic [7:0] lead;
    int unsigned pick;
    int unsigned fault;
    logic ends;
    while (stim_q.size() < N_DIRECTED + RANDOM_WORDS) begin
      q.delete();
      repeat ($urandom_range(0, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          b = 8'($urandom_range(0, 127));
          q.push_back((b == BYTE_NL) ? 8'h7F : b);
        end else if (pick < 60) begin
          q.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
          q.push_back(rand_cont(KIND_ANY));
        end else if (pick < 80) begin
          lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
          q.push_back(lead);
          q.push_back(rand_cont((lead == LEAD3_LO) ? KIND_E0 :
                                (lead == LEAD3_SURR) ? KIND_ED : KIND_ANY));
          q.push_back(rand_cont(KIND_ANY));
        end else begin
          lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
          q.push_back(lead);
          q.push_back(rand_cont((lead == LEAD4_LO) ? KIND_F0 :
                                (lead == LEAD4_HI) ? KIND_F4 : KIND_ANY));
          q.push_back(rand_cont(KIND_ANY));
          q.push_back(rand_cont(KIND_ANY));
        end
      end
      fault = $urandom_range(0, 99);
      if (q.size() != 0 && fault < 8) begin
        q.pop_back();
      end else if (q.size() != 0 && fault < 16) begin
        q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (fault < 24) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                 : 8'($urandom_range(8'hF5, 8'hFF));
        q.insert($urandom_range(0, q.size()), b);
      end else if (fault < 28) begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
      // Close the line, sometimes ending the whole input
      ends = ($urandom_range(0, 9) == 0);
      if (ends && q.size() != 0 && $urandom_range(0, 1)) begin
        for (int i = 0; i < q.size(); i++) add_word(q[i], (i == q.size() - 1), 1'b0, '0);
      end else begin
        foreach (q[i]) add_word(q[i], 1'b0, 1'b0, '0);
        add_word(BYTE_NL, ends, 1'b0, '0);
      end
    end
  endtask

  // Sender: bursts and gaps, two pauses until every line result is in
  initial begin
    int unsigned burst;
    int unsigned gap;
    int unsigned mid;
    res_word_t   want;
    for (int i = 0; i < N_DIRECTED; i++) begin
      want.line_valid       = DIRECTED_ROWS[i].ok;
      want.valid_line_count = DIRECTED_ROWS[i].cnt;
      want.input_done       = DIRECTED_ROWS[i].done;
      add_word(DIRECTED_ROWS[i].text, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed, want);
    end
    build_random_text();
    mid   = stim_q.size() / 2;
    burst = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == N_DIRECTED || i == mid) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (line_results.size() != 0) @(posedge clk_i);
      end
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= stim_q[i].w.text_byte;
      s_axis_tlast  <= stim_q[i].w.final_byte;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      burst--;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (line_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Receiver: changing stall pattern, one long hold-off
  initial begin
    int unsigned mode;
    logic        held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(8, 64)) begin
        if (!held && n_results >= HOLD_AFTER) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Monitor: predict on accepted words, check each result, watchdog
  always @(posedge clk_i) begin : monitor
    logic      closes;
    logic      moved;
    res_word_t pred;
    res_word_t got;
    res_word_t want;
    stim_t     row;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        row   = stim_q[n_taken];
        n_taken++;
        track_line_byte(in_word_t'({s_axis_tlast, s_axis_tdata}), closes, pred);
        if (closes) line_results.push_back(row.typed ? row.want : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got   = {m_axis_tlast, m_axis_tdata[RES_COUNT_W:0]};
        n_results++;
        if (line_results.size() == 0) begin
          flag_mismatch("unexpected result, count", got.valid_line_count, '0);
        end else begin
          want = line_results.pop_front();
          if (got.line_valid != want.line_valid)
            flag_mismatch("line_valid", 32'(got.line_valid), 32'(want.line_valid));
          if (got.valid_line_count != want.valid_line_count)
            flag_mismatch("valid_line_count", got.valid_line_count, want.valid_line_count);
          if (got.input_done != want.input_done)
            flag_mismatch("input_done", 32'(got.input_done), 32'(want.input_done));
        end
      end
      if (moved) begin
        idle_count = 0;
      end else begin
        idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

endmodule
